/* hw/rtl/assert_macros.svh */
// Assertion macros for the bencode tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

/* hw/rtl/btok_pkg.sv */
// Types and constants shared by the bencode tokenizer modules.
`default_nettype none
package btok_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         event_kind;
    logic signed [63:0] int_value;
    logic [30:0]        str_length;
    logic [7:0]         str_byte;
    logic               str_end;
    logic               is_key;
    logic [5:0]         nest_depth;
    logic [2:0]         error_code;
    logic               buffer_done;
    logic               parse_ok;
  } out_word_t;

  // classified byte passed from front to back
  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
    logic       is_dig;
    logic [3:0] dval;
    logic       is_ws;
  } item_t;

  typedef enum logic [7:0] {
    M_TOP       = 8'b0000_0001,
    M_ITEM      = 8'b0000_0010,
    M_INT_START = 8'b0000_0100,
    M_INT_DIG   = 8'b0000_1000,
    M_LEN       = 8'b0001_0000,
    M_STR       = 8'b0010_0000,
    M_DONE      = 8'b0100_0000,
    M_ERR       = 8'b1000_0000
  } mode_t;

  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;

  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_DICT  = 3'd1;
  localparam logic [2:0] EV_LIST  = 3'd2;
  localparam logic [2:0] EV_INT   = 3'd3;
  localparam logic [2:0] EV_STR   = 3'd4;
  localparam logic [2:0] EV_BYTE  = 3'd5;
  localparam logic [2:0] EV_CLOSE = 3'd6;
  localparam logic [2:0] EV_ERR   = 3'd7;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_VALUE   = 3'd1;
  localparam logic [2:0] ERR_KEY     = 3'd2;
  localparam logic [2:0] ERR_INT     = 3'd3;
  localparam logic [2:0] ERR_LEN     = 3'd4;
  localparam logic [2:0] ERR_DEEP    = 3'd5;
  localparam logic [2:0] ERR_TRUNC   = 3'd6;
  localparam logic [2:0] ERR_TOP     = 3'd7;

  // stack entry: bit 0 dictionary, bit 1 value due
  localparam int ENT_DICT  = 0;
  localparam int ENT_VALUE = 1;

  // floor(limit / 10) is the same for both signs; remainders differ
  localparam logic [63:0] INT_QUOT  = 64'd922337203685477580;
  localparam logic [3:0]  REM_POS   = 4'd7;
  localparam logic [3:0]  REM_NEG   = 4'd8;
  localparam logic [63:0] LEN_MAX   = 64'h0000_0000_7fff_ffff;

endpackage
`default_nettype wire

/* hw/rtl/bencode_stream_tokenizer.sv */
// Top level of the bencode stream tokenizer.
`default_nettype none
`include "assert_macros.svh"
// Bencode tokenizer: push one buffer byte per cycle with in_last on the final
// byte; one event word comes out per byte, in order. Sustained rate is one
// byte per clock while the result queue is drained, set by the parser
// section, which updates its state, the register holding the open container
// on top, and the stack RAM (read data prefetched for the parent entry)
// together. Each byte is held in the input queue, then its result word is
// written into the result queue. Each queue holds two words; input stalls
// only when the result side is not drained. The stack RAM holds MAX_DEPTH
// two-bit entries and needs no clearing pass.
module bencode_stream_tokenizer #(
  parameter int MAX_DEPTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  input  wire btok_pkg::in_word_t    in_data,
  output logic                       in_full,
  output btok_pkg::out_word_t        out_data,
  output logic                       out_empty,
  input  wire logic                  out_pop
);
  import btok_pkg::*;

  item_t     cls_item, q_item;
  out_word_t res;
  logic      q_empty, res_full, fire;
  logic [$bits(item_t)-1:0]     q_raw;
  logic [$bits(out_word_t)-1:0] o_raw;
  logic      out_is_err, out_has_code, out_is_str, out_ok_early;

  btok_front u_front (
    .in_word(in_data),
    .item   (cls_item)
  );

  btok_fifo #(.WIDTH($bits(item_t))) u_in_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (in_push),
    .wdata(cls_item),
    .full (in_full),
    .pop  (fire),
    .rdata(q_raw),
    .empty(q_empty)
  );

  assign q_item = item_t'(q_raw);
  assign fire   = !q_empty && !res_full;

  btok_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .item (q_item),
    .res  (res)
  );

  btok_fifo #(.WIDTH($bits(out_word_t))) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (fire),
    .wdata(res),
    .full (res_full),
    .pop  (out_pop),
    .rdata(o_raw),
    .empty(out_empty)
  );

  assign out_data = out_word_t'(o_raw);

  assign out_is_err   = (out_data.event_kind == EV_ERR);
  assign out_has_code = (out_data.error_code != ERR_NONE);
  assign out_is_str   = (out_data.event_kind inside {EV_STR, EV_BYTE});
  assign out_ok_early = out_data.parse_ok && !out_data.buffer_done;

  `ASSERT_NEVER(a_ok_needs_done, clk, rst_n, !out_empty && out_ok_early)
  `ASSERT_NEVER(a_err_code, clk, rst_n, !out_empty && (out_is_err != out_has_code))
  `ASSERT_NEVER(a_end_on_str, clk, rst_n, !out_empty && out_data.str_end && !out_is_str)
  `ASSERT_NEVER(a_depth_max, clk, rst_n, !out_empty && (int'(out_data.nest_depth) > MAX_DEPTH))
endmodule
`default_nettype wire

/* hw/rtl/btok_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module btok_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hw/rtl/btok_fifo.sv */
// Two-entry word queue used before and after the parser section.
`default_nettype none
module btok_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);
  logic [WIDTH-1:0] store_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rdata   = store_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = wp_r ^ do_push;
    rp_nxt  = rp_r ^ do_pop;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      store_r[wp_r] <= wdata;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/btok_front.sv */
// Front section: classifies each incoming byte for the parser.
`default_nettype none
module btok_front (
  input  wire btok_pkg::in_word_t in_word,
  output btok_pkg::item_t         item
);
  import btok_pkg::*;

  always_comb begin
    item.byte_val = in_word.in_byte;
    item.last     = in_word.in_last;
    item.is_dig   = (in_word.in_byte >= 8'h30) && (in_word.in_byte <= 8'h39);
    item.dval     = in_word.in_byte[3:0];
    // space, or tab through carriage return
    item.is_ws    = (in_word.in_byte == 8'h20) ||
                    ((in_word.in_byte >= 8'h09) && (in_word.in_byte <= 8'h0d));
  end
endmodule
`default_nettype wire

/* hw/rtl/btok_back.sv */
// Back section: parser state, container stack and event generation.
`default_nettype none
module btok_back #(
  parameter int MAX_DEPTH = 32,
  localparam int DW = $clog2(MAX_DEPTH + 1),
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                fire,
  input  wire btok_pkg::item_t     item,
  output btok_pkg::out_word_t      res
);
  import btok_pkg::*;

  mode_t        mode_r, mode_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [1:0]   top_r, top_nxt;
  logic [63:0]  acc_r, acc_nxt;
  logic         neg_r, neg_nxt, seen_r, seen_nxt, sticky_r, sticky_nxt;
  logic [30:0]  rem_r, rem_nxt;
  logic         byp_r;
  logic [1:0]   bypd_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [1:0]    rdata, below;
  logic          top_key;
  logic [63:0]   acc10, thr;
  logic [3:0]    rem_lim;
  logic [DW-1:0] dsub;

  btok_ram #(.WIDTH(2), .DEPTH(MAX_DEPTH)) u_stack (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(top_r),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign below   = byp_r ? bypd_r : rdata;
  assign top_key = (depth_r != '0) && top_r[ENT_DICT] && !top_r[ENT_VALUE];
  assign acc10   = (acc_r << 3) + (acc_r << 1);
  assign rem_lim = neg_r ? REM_NEG : REM_POS;
  assign thr     = INT_QUOT - {63'd0, (item.dval > rem_lim)};

  always_comb begin
    mode_nxt   = mode_r;
    depth_nxt  = depth_r;
    top_nxt    = top_r;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    seen_nxt   = seen_r;
    rem_nxt    = rem_r;
    sticky_nxt = sticky_r;
    we         = 1'b0;
    dsub       = depth_r - DW'(1);
    waddr      = dsub[AW-1:0];
    res        = '0;

    unique case (mode_r) inside
      M_TOP: begin
        if (item.byte_val == CH_D) begin
          top_nxt        = 2'b01;
          depth_nxt      = depth_r + DW'(1);
          res.event_kind = EV_DICT;
          mode_nxt       = M_ITEM;
        end else begin
          res.event_kind = EV_ERR;
          res.error_code = ERR_TOP;
          mode_nxt       = M_ERR;
          sticky_nxt     = 1'b1;
        end
      end
      M_ITEM: begin
        if (item.byte_val == CH_E) begin
          if (depth_r != '0 && top_r[ENT_DICT] && top_r[ENT_VALUE]) begin
            res.event_kind = EV_ERR;
            res.error_code = ERR_VALUE;
            mode_nxt       = M_ERR;
            sticky_nxt     = 1'b1;
          end else begin
            if (depth_r != '0) begin
              depth_nxt = depth_r - DW'(1);
            end
            res.event_kind = EV_CLOSE;
            if (depth_nxt == '0) begin
              mode_nxt = M_DONE;
            end else begin
              // parent becomes top; its value just finished
              top_nxt  = below;
              if (below[ENT_DICT]) begin
                top_nxt[ENT_VALUE] = ~below[ENT_VALUE];
              end
              mode_nxt = M_ITEM;
            end
          end
        end else if (top_key) begin
          if (item.is_dig) begin
            acc_nxt  = {60'd0, item.dval};
            mode_nxt = M_LEN;
          end else begin
            res.event_kind = EV_ERR;
            res.error_code = ERR_KEY;
            mode_nxt       = M_ERR;
            sticky_nxt     = 1'b1;
          end
        end else if (item.byte_val == CH_D || item.byte_val == CH_L) begin
          if (depth_r >= DW'(MAX_DEPTH)) begin
            res.event_kind = EV_ERR;
            res.error_code = ERR_DEEP;
            mode_nxt       = M_ERR;
            sticky_nxt     = 1'b1;
          end else begin
            we             = (depth_r != '0);
            top_nxt        = {1'b0, item.byte_val == CH_D};
            depth_nxt      = depth_r + DW'(1);
            res.event_kind = (item.byte_val == CH_D) ? EV_DICT : EV_LIST;
            mode_nxt       = M_ITEM;
          end
        end else if (item.byte_val == CH_I) begin
          acc_nxt  = '0;
          neg_nxt  = 1'b0;
          seen_nxt = 1'b0;
          mode_nxt = M_INT_START;
        end else if (item.is_dig) begin
          acc_nxt  = {60'd0, item.dval};
          mode_nxt = M_LEN;
        end else begin
          res.event_kind = EV_ERR;
          res.error_code = ERR_VALUE;
          mode_nxt       = M_ERR;
          sticky_nxt     = 1'b1;
        end
      end
      M_INT_START, M_INT_DIG: begin
        if (mode_r == M_INT_START && item.is_ws) begin
          mode_nxt = mode_r;
        end else if (mode_r == M_INT_START &&
                     (item.byte_val == CH_MINUS || item.byte_val == CH_PLUS)) begin
          neg_nxt  = (item.byte_val == CH_MINUS);
          mode_nxt = M_INT_DIG;
        end else if (item.is_dig) begin
          if (acc_r > thr) begin
            res.event_kind = EV_ERR;
            res.error_code = ERR_INT;
            mode_nxt       = M_ERR;
            sticky_nxt     = 1'b1;
          end else begin
            acc_nxt  = acc10 + {60'd0, item.dval};
            seen_nxt = 1'b1;
            mode_nxt = M_INT_DIG;
          end
        end else if (item.byte_val == CH_E && (mode_r == M_INT_START || seen_r)) begin
          res.event_kind = EV_INT;
          res.int_value  = neg_r ? -acc_r : acc_r;
          if (depth_r != '0 && top_r[ENT_DICT]) begin
            top_nxt[ENT_VALUE] = ~top_r[ENT_VALUE];
          end
          mode_nxt = M_ITEM;
        end else begin
          res.event_kind = EV_ERR;
          res.error_code = ERR_INT;
          mode_nxt       = M_ERR;
          sticky_nxt     = 1'b1;
        end
      end
      M_LEN: begin
        if (item.is_dig) begin
          acc_nxt = acc10 + {60'd0, item.dval};
          if (acc_nxt > LEN_MAX) begin
            res.event_kind = EV_ERR;
            res.error_code = ERR_LEN;
            mode_nxt       = M_ERR;
            sticky_nxt     = 1'b1;
          end
        end else if (item.byte_val == CH_COLON) begin
          res.event_kind = EV_STR;
          res.str_length = acc_r[30:0];
          res.is_key     = top_key;
          rem_nxt        = acc_r[30:0];
          acc_nxt        = '0;
          if (acc_r[30:0] == '0) begin
            res.str_end = 1'b1;
            if (depth_r != '0 && top_r[ENT_DICT]) begin
              top_nxt[ENT_VALUE] = ~top_r[ENT_VALUE];
            end
            mode_nxt = M_ITEM;
          end else begin
            mode_nxt = M_STR;
          end
        end else begin
          res.event_kind = EV_ERR;
          res.error_code = ERR_LEN;
          mode_nxt       = M_ERR;
          sticky_nxt     = 1'b1;
        end
      end
      M_STR: begin
        res.event_kind = EV_BYTE;
        res.str_byte   = item.byte_val;
        res.is_key     = top_key;
        if (rem_r != '0) begin
          rem_nxt = rem_r - 31'd1;
        end
        if (rem_nxt == '0) begin
          res.str_end = 1'b1;
          if (depth_r != '0 && top_r[ENT_DICT]) begin
            top_nxt[ENT_VALUE] = ~top_r[ENT_VALUE];
          end
          mode_nxt = M_ITEM;
        end
      end
      M_DONE, M_ERR: begin
        mode_nxt = mode_r;
      end
      default: begin
        mode_nxt = M_ERR;
      end
    endcase

    res.nest_depth = 6'(depth_nxt);

    if (item.last) begin
      res.buffer_done = 1'b1;
      if (mode_nxt != M_DONE && mode_nxt != M_ERR) begin
        res.int_value  = '0;
        res.str_length = '0;
        res.str_byte   = '0;
        res.str_end    = 1'b0;
        res.is_key     = 1'b0;
        res.event_kind = EV_ERR;
        res.error_code = ERR_TRUNC;
        mode_nxt       = M_ERR;
        sticky_nxt     = 1'b1;
      end
      res.parse_ok = (mode_nxt == M_DONE) && !sticky_nxt;
      // buffer finished: back to reset state
      mode_nxt   = M_TOP;
      depth_nxt  = '0;
      acc_nxt    = '0;
      neg_nxt    = 1'b0;
      seen_nxt   = 1'b0;
      rem_nxt    = '0;
      sticky_nxt = 1'b0;
    end

    if (!fire) begin
      we = 1'b0;
    end
  end

  // read the entry just under the next top so it is ready for a close
  always_comb begin
    logic [DW-1:0] dn, ra;
    dn = fire ? depth_nxt : depth_r;
    ra = dn - DW'(2);
    raddr = ra[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_TOP;
      depth_r  <= '0;
      acc_r    <= '0;
      neg_r    <= 1'b0;
      seen_r   <= 1'b0;
      rem_r    <= '0;
      sticky_r <= 1'b0;
      byp_r    <= 1'b0;
    end else begin
      if (fire) begin
        mode_r   <= mode_nxt;
        depth_r  <= depth_nxt;
        acc_r    <= acc_nxt;
        neg_r    <= neg_nxt;
        seen_r   <= seen_nxt;
        rem_r    <= rem_nxt;
        sticky_r <= sticky_nxt;
      end
      byp_r <= we && (waddr == raddr);
    end
    if (fire) begin
      top_r <= top_nxt;
    end
    bypd_r <= top_r;
  end
endmodule
`default_nettype wire
